// ===== src/swl_pkg.sv =====
// shared constants, types and helpers of the sliding window log rate limiter
`default_nettype none

package swl_pkg;

    // field widths
    localparam int CUST_W   = 4;
    localparam int TS_W     = 32;
    localparam int MAXREQ_W = 4;
    localparam int WIN_W    = 16;

    // sizing of the per-customer logs
    localparam int NUM_CUSTOMERS = 16;
    localparam int LOG_DEPTH     = 8;
    localparam int CUST_AW = (NUM_CUSTOMERS > 1) ? $clog2(NUM_CUSTOMERS) : 1;
    localparam int PTR_W   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W   = $clog2(LOG_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    // request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IDX_MAX_REQUESTS   = 1'b0;
    localparam logic REG_IDX_WINDOW_SECONDS = 1'b1;
    localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = 4'd3;
    localparam logic [WIN_W-1:0]    WINDOW_RESET = 16'd10;

    // one request item
    typedef struct packed {
        logic [CUST_W-1:0] customer_id;
        logic [TS_W-1:0]   timestamp;
    } req_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [MAXREQ_W-1:0] max_requests;
        logic [WIN_W-1:0]    window_seconds;
    } cfg_t;

    // back end sequencer states
    typedef enum logic {
        ST_LOOKUP,
        ST_EXEC
    } back_state_t;

    // position in a circular log, sum is below twice the depth
    function automatic logic [PTR_W-1:0] wrap_pos(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = s;
        if (s >= SUM_W'(LOG_DEPTH))
        begin
            r = s - SUM_W'(LOG_DEPTH);
        end
        return r[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/swl_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module swl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/swl_cfg.sv =====
// apb configuration registers of the rate limiter
`default_nettype none

module swl_cfg
    import swl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    logic [MAXREQ_W-1:0] max_requests_reg;
    logic [WIN_W-1:0]    window_seconds_reg;
    logic                wr_en;
    logic                reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_requests_reg   <= MAXREQ_RESET;
            window_seconds_reg <= WINDOW_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_IDX_MAX_REQUESTS:   max_requests_reg   <= pwdata[MAXREQ_W-1:0];
                REG_IDX_WINDOW_SECONDS: window_seconds_reg <= pwdata[WIN_W-1:0];
                default:                max_requests_reg   <= max_requests_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_IDX_MAX_REQUESTS:   prdata = PDATA_W'(max_requests_reg);
            REG_IDX_WINDOW_SECONDS: prdata = PDATA_W'(window_seconds_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.max_requests   = max_requests_reg;
    assign cfg.window_seconds = window_seconds_reg;

endmodule

`default_nettype wire

// ===== src/swl_front.sv =====
// request intake and short queue toward the back end
`default_nettype none

module swl_front
    import swl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CUST_W-1:0] customer_id,
    input  wire logic [TS_W-1:0]   timestamp,
    output logic                   q_valid,
    output req_t                   q_item,
    input  wire logic              q_pop
);

    req_t                slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_next;
    logic [Q_CNT_W-1:0]  fill_reg;
    logic [Q_CNT_W-1:0]  fill_next;
    logic                push;
    logic                pop;

    assign in_ready = (fill_reg != Q_CNT_W'(Q_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].customer_id <= customer_id;
            slot_reg[wr_ptr_reg].timestamp   <= timestamp;
        end
    end

endmodule

`default_nettype wire

// ===== src/swl_back.sv =====
// log lookup, expiry decision, log update and result register
`default_nettype none

module swl_back
    import swl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic q_valid,
    input  wire req_t q_item,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic      allowed
);

    back_state_t         state_reg;
    back_state_t         state_next;
    req_t                job_reg;
    logic [PTR_W-1:0]    log_head_reg  [NUM_CUSTOMERS];
    logic [CNT_W-1:0]    log_count_reg [NUM_CUSTOMERS];
    logic [PTR_W-1:0]    log_head_next;
    logic [CNT_W-1:0]    log_count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                allowed_reg;
    logic                allowed_next;

    logic                rd_en;
    logic [CUST_AW-1:0]  rd_addr;
    logic [TS_W-1:0]     rd_data [LOG_DEPTH];
    logic                wr_en;
    logic [PTR_W-1:0]    wr_pos;

    logic [CUST_AW-1:0]  job_idx;
    logic                in_range;
    logic [PTR_W-1:0]    head;
    logic [CNT_W-1:0]    count;
    logic [CNT_W-1:0]    lim;
    logic                below_limit;
    logic [LOG_DEPTH-1:0] expired;
    logic [CNT_W-1:0]    pops;
    logic                run;
    logic [PTR_W-1:0]    pos_k;
    logic [TS_W-1:0]     age_k;
    logic                decide_allow;
    logic                finish;

    // one ram bank per log slot, all slots of a customer read together
    for (genvar b = 0; b < LOG_DEPTH; b++)
    begin : g_bank
        swl_ram #(
            .WIDTH (TS_W),
            .DEPTH (NUM_CUSTOMERS)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en && (wr_pos == PTR_W'(b))),
            .waddr (job_idx),
            .wdata (job_reg.timestamp),
            .re    (rd_en),
            .raddr (rd_addr),
            .rdata (rd_data[b])
        );
    end

    // per-customer log state for the item at work
    assign job_idx  = job_reg.customer_id[CUST_AW-1:0];
    assign in_range = (32'(job_reg.customer_id) < NUM_CUSTOMERS);
    assign head     = log_head_reg[job_idx];
    assign count    = log_count_reg[job_idx];

    // limit clamped to one .. log depth
    always_comb
    begin
        if (cfg.max_requests == '0)
        begin
            lim = CNT_W'(1);
        end
        else if (32'(cfg.max_requests) > LOG_DEPTH)
        begin
            lim = CNT_W'(LOG_DEPTH);
        end
        else
        begin
            lim = CNT_W'(cfg.max_requests);
        end
    end

    assign below_limit = (count < lim);

    // age test of every logged entry, oldest first, and run of expired ones
    always_comb
    begin
        expired = '0;
        pops    = '0;
        run     = 1'b1;
        pos_k   = '0;
        age_k   = '0;
        for (int k = 0; k < LOG_DEPTH; k++)
        begin
            pos_k      = wrap_pos(SUM_W'(head) + SUM_W'(k));
            age_k      = job_reg.timestamp - rd_data[pos_k];
            expired[k] = (SUM_W'(k) < SUM_W'(count)) && (age_k > TS_W'(cfg.window_seconds));
            run        = run && expired[k];
            pops       = pops + CNT_W'(run);
        end
    end

    // decision and new log state
    assign decide_allow = in_range && (below_limit || expired[0]);
    assign wr_pos       = wrap_pos(SUM_W'(head) + SUM_W'(count));

    always_comb
    begin
        if (below_limit)
        begin
            log_head_next  = head;
            log_count_next = count + 1'b1;
        end
        else
        begin
            log_head_next  = wrap_pos(SUM_W'(head) + SUM_W'(pops));
            log_count_next = count - pops + 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOOKUP:
            begin
                if (q_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            default: state_next = ST_LOOKUP;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop  = 1'b0;
        rd_en  = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            ST_LOOKUP:
            begin
                q_pop = q_valid;
                rd_en = q_valid;
            end
            ST_EXEC:
            begin
                finish = !out_valid_reg || out_ready;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign rd_addr = q_item.customer_id[CUST_AW-1:0];
    assign wr_en   = finish && decide_allow;

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        allowed_next   = allowed_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            allowed_next   = decide_allow;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOOKUP;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CUSTOMERS; i++)
            begin
                log_head_reg[i]  <= '0;
                log_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                log_head_reg[job_idx]  <= log_head_next;
                log_count_reg[job_idx] <= log_count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        allowed_reg <= allowed_next;
        if (q_pop)
        begin
            job_reg <= q_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign allowed   = allowed_reg;

endmodule

`default_nettype wire

// ===== src/sliding_window_log_rate_limiter_core.sv =====
// top level of the sliding window log rate limiter
//
// channel   direction  handshake                  payload
// in        input      in_valid / in_ready        customer_id[3:0], timestamp[31:0]
// out       output     out_valid / out_ready      allowed
// config    input      apb psel/penable/pwrite    paddr[2:0], pwdata[31:0], prdata[31:0]
//
// in the back end each item is first looked up, reading all log slots of the
// customer from the slot rams, then executed: ages compared, decided, written back.
// a two-entry queue in front keeps intake going while the back end works,
// and the result register frees the back end as soon as a result is taken.
// reset clears all log counts and heads at once; slot rams need no clearing.
// a stalled out channel holds the back end in its decide cycle.
`default_nettype none

module sliding_window_log_rate_limiter_core
    import swl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [CUST_W-1:0]  customer_id,
    input  wire logic [TS_W-1:0]    timestamp,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    allowed,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    cfg_t cfg;
    logic q_valid;
    req_t q_item;
    logic q_pop;

    // configuration registers
    swl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // intake and queue
    swl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .customer_id (customer_id),
        .timestamp   (timestamp),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // decision and log update
    swl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .allowed   (allowed)
    );

endmodule

`default_nettype wire
